FILE: rtl/psvm_pkg.sv
// Shared constants, function codes and control types for the sample voice mixer.
// No dependencies.
package psvm_pkg;

    localparam int VOICES_DEF         = 16;
    localparam int SOUNDS_DEF         = 12;
    localparam int SAMPLE_FRAMES_DEF  = 65536;
    localparam int GAIN_FRAC_BITS_DEF = 15;

    localparam int SMP_W  = 16;
    localparam int GAIN_W = 16;
    localparam int ID_W   = 4;
    localparam int BUSY_W = 5;

    localparam logic [1:0] FUNC_LOAD = 2'd0;
    localparam logic [1:0] FUNC_DESC = 2'd1;
    localparam logic [1:0] FUNC_TRIG = 2'd2;
    localparam logic [1:0] FUNC_MIX  = 2'd3;

    localparam logic signed [SMP_W-1:0] MIX_MAX = 16'sd32767;
    localparam logic signed [SMP_W-1:0] MIX_MIN = -16'sd32767;

    typedef struct packed {
        logic clr;
        logic valid;
    } t_mac_ctl;

endpackage

FILE: rtl/psvm_ifs.sv
// Valid/ready channel interfaces for the mixer: command beats in, frame beats out.
// Depends on nothing; field widths follow the command and frame formats.
interface psvm_in_if;
    logic               valid;
    logic               ready;
    logic [1:0]         func;
    logic [15:0]        sample_addr;
    logic signed [15:0] sample_left;
    logic signed [15:0] sample_right;
    logic [3:0]         sound_id;
    logic [15:0]        sound_start;
    logic [15:0]        sound_length;
    logic [15:0]        left_gain;
    logic [15:0]        right_gain;

    modport source (output valid, func, sample_addr, sample_left, sample_right, sound_id,
                    sound_start, sound_length, left_gain, right_gain, input ready);
    modport sink   (input valid, func, sample_addr, sample_left, sample_right, sound_id,
                    sound_start, sound_length, left_gain, right_gain, output ready);
endinterface

interface psvm_out_if;
    logic               valid;
    logic               ready;
    logic signed [15:0] out_left;
    logic signed [15:0] out_right;
    logic [4:0]         voices_busy;

    modport source (output valid, out_left, out_right, voices_busy, input ready);
    modport sink   (input valid, out_left, out_right, voices_busy, output ready);
endinterface

FILE: rtl/polyphonic_sample_voice_mixer.sv
// Polyphonic sample mixer: load, describe and trigger take one beat; a trigger scans
// voices one per cycle; a frame is produced by the voice sequencer feeding one stereo
// MAC through the sample memory port.
// One command at a time; a finished frame may wait in the output register meanwhile.
// Synchronous active-low reset clears voices, sound table and handshake state; the
// sample memory is not cleared. SAMPLE_FRAMES must be a power of two.
module polyphonic_sample_voice_mixer #(
    parameter int VOICES         = psvm_pkg::VOICES_DEF,
    parameter int SOUNDS         = psvm_pkg::SOUNDS_DEF,
    parameter int SAMPLE_FRAMES  = psvm_pkg::SAMPLE_FRAMES_DEF,
    parameter int GAIN_FRAC_BITS = psvm_pkg::GAIN_FRAC_BITS_DEF
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    psvm_in_if.sink    i_in,
    psvm_out_if.source o_out
);
    import psvm_pkg::*;

    localparam int AW = $clog2(SAMPLE_FRAMES);
    localparam int VW = (VOICES > 1) ? $clog2(VOICES) : 1;
    localparam int SW = (SOUNDS > 1) ? $clog2(SOUNDS) : 1;
    localparam int CW = $clog2(VOICES + 2);

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_TRIG = 2'd1;
    localparam logic [1:0] S_MIX  = 2'd2;
    localparam logic [1:0] S_DONE = 2'd3;

    logic [1:0]              r_state;
    logic [1:0]              n_state;
    logic [CW-1:0]           r_cnt;
    logic [CW-1:0]           n_cnt;

    logic [ID_W-1:0]         r_id;
    logic [GAIN_W-1:0]       r_lg;
    logic [GAIN_W-1:0]       r_rg;
    logic [VW-1:0]           r_slot;
    logic [15:0]             r_best;
    logic                    r_found;
    logic [BUSY_W-1:0]       r_busy;

    logic                    r_s1_valid;
    logic [GAIN_W-1:0]       r_s1_lg;
    logic [GAIN_W-1:0]       r_s1_rg;

    logic                    r_out_valid;
    logic signed [SMP_W-1:0] r_out_left;
    logic signed [SMP_W-1:0] r_out_right;
    logic [BUSY_W-1:0]       r_out_busy;

    logic [15:0]             r_start [SOUNDS];
    logic [15:0]             r_len   [SOUNDS];
    logic [ID_W-1:0]         r_vsound [VOICES];
    logic [15:0]             r_vpos   [VOICES];
    logic [GAIN_W-1:0]       r_vlg    [VOICES];
    logic [GAIN_W-1:0]       r_vrg    [VOICES];
    logic [VOICES-1:0]       r_vact;

    logic                    acc_in;
    logic                    in_id_ok;
    logic [SW-1:0]           tab_idx;
    logic [15:0]             tab_len;
    logic [15:0]             tab_start;
    logic [VW-1:0]           vi;
    logic                    v_id_ok;
    logic [15:0]             v_len;
    logic [15:0]             v_pos;
    logic [15:0]             v_pos1;
    logic                    mix_a;
    logic                    v_hit;
    logic                    v_keep;
    logic                    better;
    logic                    last;
    logic                    vw_en;
    logic [VW-1:0]           vw_idx;
    logic                    out_load;
    logic                    tab_we;

    logic [31:0]             mem_rdata;
    logic [15:0]             mem_raddr16;
    t_mac_ctl                mac_ctl;
    logic signed [SMP_W-1:0] acc_l;
    logic signed [SMP_W-1:0] acc_r;
    logic                    mac_busy;

    assign i_in.ready = (r_state == S_IDLE);
    assign acc_in     = i_in.valid && i_in.ready;

    assign in_id_ok  = {1'b0, i_in.sound_id} < 5'(SOUNDS);
    assign vi        = r_cnt[VW-1:0];
    assign tab_idx   = (r_state == S_IDLE) ? i_in.sound_id[SW-1:0] : r_vsound[vi][SW-1:0];
    assign tab_len   = r_len[tab_idx];
    assign tab_start = r_start[tab_idx];

    assign v_id_ok = {1'b0, r_vsound[vi]} < 5'(SOUNDS);
    assign v_len   = v_id_ok ? tab_len : 16'd0;
    assign v_pos   = r_vpos[vi];
    assign v_pos1  = v_pos + 16'd1;
    assign mix_a   = (r_state == S_MIX) && (r_cnt < CW'(VOICES));
    assign v_hit   = mix_a && r_vact[vi] && (v_pos < v_len);
    assign v_keep  = v_hit && (v_pos1 != v_len);

    assign better  = !r_found || (v_pos > r_best);
    assign last    = (r_cnt == CW'(VOICES - 1));
    assign tab_we  = acc_in && (i_in.func == FUNC_DESC) && in_id_ok;

    assign mem_raddr16 = tab_start + v_pos;
    assign out_load    = (r_state == S_DONE) && (!r_out_valid || o_out.ready);

    always_comb begin
        n_state = r_state;
        n_cnt   = r_cnt;
        vw_en   = 1'b0;
        vw_idx  = vi;
        unique case (r_state)
            S_IDLE: begin
                n_cnt = '0;
                if (acc_in) begin
                    unique case (i_in.func)
                        FUNC_LOAD: n_state = S_IDLE;
                        FUNC_DESC: n_state = S_IDLE;
                        FUNC_TRIG: begin
                            if (in_id_ok && (tab_len != 16'd0)) begin
                                n_state = S_TRIG;
                            end
                        end
                        FUNC_MIX:  n_state = S_MIX;
                        default:   n_state = S_IDLE;
                    endcase
                end
            end
            S_TRIG: begin
                n_cnt = r_cnt + CW'(1);
                if (!r_vact[vi]) begin
                    vw_en   = 1'b1;
                    n_state = S_IDLE;
                end else if (last) begin
                    vw_en   = 1'b1;
                    vw_idx  = better ? vi : r_slot;
                    n_state = S_IDLE;
                end
            end
            S_MIX: begin
                n_cnt = r_cnt + CW'(1);
                if (r_cnt == CW'(VOICES + 1)) begin
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
                if (out_load) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_cnt       <= '0;
            r_vact      <= '0;
            r_s1_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_found     <= 1'b0;
            r_busy      <= '0;
            for (int s = 0; s < SOUNDS; s++) begin
                r_start[s] <= '0;
                r_len[s]   <= '0;
            end
            for (int v = 0; v < VOICES; v++) begin
                r_vsound[v] <= '0;
                r_vpos[v]   <= '0;
                r_vlg[v]    <= '0;
                r_vrg[v]    <= '0;
            end
        end else begin
            r_state    <= n_state;
            r_cnt      <= n_cnt;
            r_s1_valid <= v_hit;

            if (tab_we) begin
                r_start[i_in.sound_id[SW-1:0]] <= i_in.sound_start;
                r_len[i_in.sound_id[SW-1:0]]   <= i_in.sound_length;
            end

            if (acc_in) begin
                r_found <= 1'b0;
                r_busy  <= '0;
            end

            // track the oldest busy voice while scanning
            if ((r_state == S_TRIG) && r_vact[vi] && better) begin
                r_found <= 1'b1;
                r_best  <= v_pos;
                r_slot  <= vi;
            end

            if (vw_en) begin
                r_vsound[vw_idx] <= r_id;
                r_vpos[vw_idx]   <= '0;
                r_vlg[vw_idx]    <= r_lg;
                r_vrg[vw_idx]    <= r_rg;
                r_vact[vw_idx]   <= 1'b1;
            end

            // advance the voice and retire it once it reaches the sound's length
            if (mix_a && r_vact[vi]) begin
                r_vact[vi] <= v_keep;
                if (v_hit) begin
                    r_vpos[vi] <= v_pos1;
                end
                if (v_keep) begin
                    r_busy <= r_busy + BUSY_W'(1);
                end
            end

            if (out_load) begin
                r_out_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (acc_in) begin
            r_id <= i_in.sound_id;
            r_lg <= i_in.left_gain;
            r_rg <= i_in.right_gain;
        end
        if (v_hit) begin
            r_s1_lg <= r_vlg[vi];
            r_s1_rg <= r_vrg[vi];
        end
        if (out_load) begin
            r_out_left  <= acc_l;
            r_out_right <= acc_r;
            r_out_busy  <= r_busy;
        end
    end

    psvm_sample_mem #(
        .SAMPLE_FRAMES (SAMPLE_FRAMES)
    ) u_mem (
        .i_clk   (i_clk),
        .i_we    (acc_in && (i_in.func == FUNC_LOAD)),
        .i_waddr (i_in.sample_addr[AW-1:0]),
        .i_wdata ({i_in.sample_right, i_in.sample_left}),
        .i_re    (v_hit),
        .i_raddr (mem_raddr16[AW-1:0]),
        .o_rdata (mem_rdata)
    );

    assign mac_ctl.clr   = acc_in && (i_in.func == FUNC_MIX);
    assign mac_ctl.valid = r_s1_valid;

    psvm_mac #(
        .GAIN_FRAC_BITS (GAIN_FRAC_BITS)
    ) u_mac (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_ctl    (mac_ctl),
        .i_smp_l  ($signed(mem_rdata[15:0])),
        .i_smp_r  ($signed(mem_rdata[31:16])),
        .i_gain_l (r_s1_lg),
        .i_gain_r (r_s1_rg),
        .o_acc_l  (acc_l),
        .o_acc_r  (acc_r),
        .o_busy   (mac_busy)
    );

    assign o_out.valid       = r_out_valid;
    assign o_out.out_left    = r_out_left;
    assign o_out.out_right   = r_out_right;
    assign o_out.voices_busy = r_out_busy;

`ifndef ASSERT_OFF
    a_trig_leaves_voice: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_TRIG && n_state == S_IDLE) |=> (r_vact != '0))
        else $error("trigger finished with no active voice");

    a_done_drained: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DONE) |-> (!r_s1_valid && !mac_busy))
        else $error("frame closed while MAC pipeline still busy");

    a_out_saturated: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> (r_out_left != 16'sh8000 && r_out_right != 16'sh8000))
        else $error("output frame outside saturation range");
`endif

endmodule

FILE: rtl/psvm_sample_mem.sv
// Stereo sample memory: one write port, one read port with registered read data.
// Depends on nothing.
module psvm_sample_mem #(
    parameter int SAMPLE_FRAMES = 65536
) (
    input  logic                             i_clk,
    input  logic                             i_we,
    input  logic [$clog2(SAMPLE_FRAMES)-1:0] i_waddr,
    input  logic [31:0]                      i_wdata,
    input  logic                             i_re,
    input  logic [$clog2(SAMPLE_FRAMES)-1:0] i_raddr,
    output logic [31:0]                      o_rdata
);

    logic [31:0] r_mem [SAMPLE_FRAMES];
    logic [31:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

FILE: rtl/psvm_mac.sv
// Stereo multiply, scale and saturating accumulate unit, one voice per beat.
// Depends on psvm_pkg.
module psvm_mac #(
    parameter int GAIN_FRAC_BITS = 15
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  psvm_pkg::t_mac_ctl   i_ctl,
    input  logic signed [15:0]   i_smp_l,
    input  logic signed [15:0]   i_smp_r,
    input  logic [15:0]          i_gain_l,
    input  logic [15:0]          i_gain_r,
    output logic signed [15:0]   o_acc_l,
    output logic signed [15:0]   o_acc_r,
    output logic                 o_busy
);
    import psvm_pkg::*;

    localparam logic signed [33:0] SAT_HI = 34'sd32767;
    localparam logic signed [33:0] SAT_LO = -34'sd32767;

    logic                     r_pv;
    logic signed [32:0]       r_pl;
    logic signed [32:0]       r_pr;
    logic signed [SMP_W-1:0]  r_acc_l;
    logic signed [SMP_W-1:0]  r_acc_r;
    logic signed [32:0]       sh_l;
    logic signed [32:0]       sh_r;
    logic signed [33:0]       sum_l;
    logic signed [33:0]       sum_r;
    logic signed [SMP_W-1:0]  n_acc_l;
    logic signed [SMP_W-1:0]  n_acc_r;

    always_comb begin
        sh_l  = r_pl >>> GAIN_FRAC_BITS;
        sh_r  = r_pr >>> GAIN_FRAC_BITS;
        sum_l = $signed({{18{r_acc_l[SMP_W-1]}}, r_acc_l}) + $signed({sh_l[32], sh_l});
        sum_r = $signed({{18{r_acc_r[SMP_W-1]}}, r_acc_r}) + $signed({sh_r[32], sh_r});
        if (sum_l > SAT_HI) begin
            n_acc_l = MIX_MAX;
        end else if (sum_l < SAT_LO) begin
            n_acc_l = MIX_MIN;
        end else begin
            n_acc_l = sum_l[SMP_W-1:0];
        end
        if (sum_r > SAT_HI) begin
            n_acc_r = MIX_MAX;
        end else if (sum_r < SAT_LO) begin
            n_acc_r = MIX_MIN;
        end else begin
            n_acc_r = sum_r[SMP_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pv <= 1'b0;
        end else begin
            r_pv <= i_ctl.valid;
        end
    end

    // multiply stage
    always_ff @(posedge i_clk) begin
        if (i_ctl.valid) begin
            r_pl <= i_smp_l * $signed({1'b0, i_gain_l});
            r_pr <= i_smp_r * $signed({1'b0, i_gain_r});
        end
    end

    // accumulate stage
    always_ff @(posedge i_clk) begin
        if (i_ctl.clr) begin
            r_acc_l <= '0;
            r_acc_r <= '0;
        end else if (r_pv) begin
            r_acc_l <= n_acc_l;
            r_acc_r <= n_acc_r;
        end
    end

    assign o_acc_l = r_acc_l;
    assign o_acc_r = r_acc_r;
    assign o_busy  = r_pv;

endmodule
